// File: rtl/core/assert_macros.svh
// Assertion macros used by the deframer back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/fsda_pkg.sv
// Package: constants, sync word and shared types of the deframer.
package fsda_pkg;

  localparam int LINES       = 8;
  localparam int FRAME_BYTES = 165;

  localparam int SYNC_LEN    = 5;
  localparam int PAYLOAD_LEN = FRAME_BYTES - SYNC_LEN;

  localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int POS_W  = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
  localparam int PROG_W = 3;
  localparam int CNT_W  = 20;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 1'd1;

  localparam logic signed [7:0] THRESHOLD_RESET = 8'sd0;
  localparam logic [CNT_W-1:0]  HOLD_RESET      = 20'd8000;

  localparam logic [7:0] SYNC_A = 8'h0a;
  localparam logic [7:0] SYNC_B = 8'hff;
  localparam logic [7:0] SYNC_WORD [SYNC_LEN] = '{SYNC_A, SYNC_B, SYNC_A, SYNC_B, SYNC_A};

  typedef struct packed {
    logic              is_sample;
    logic [LINE_W-1:0] line;
    logic [7:0]        value;
    logic              sync_found;
    logic              last;
  } item_t;

  typedef struct packed {
    logic signed [7:0] threshold;
    logic [CNT_W-1:0]  hold;
  } cfg_t;

endpackage

// File: rtl/core/fsda_if.sv
// Channel interfaces: input bytes, results and configuration writes.
interface fsda_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface fsda_result_if;
  logic              valid;
  logic              ready;
  logic              sample_valid;
  logic [2:0]        line_index;
  logic signed [7:0] sample_value;
  logic              line_active;
  logic              sync_found;
  logic              frame_last;
  modport source (output valid, output sample_valid, output line_index,
                  output sample_value, output line_active, output sync_found,
                  output frame_last, input ready);
  modport sink (input valid, input sample_valid, input line_index,
                input sample_value, input line_active, input sync_found,
                input frame_last, output ready);
endinterface

interface fsda_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [fsda_pkg::CFG_IDX_W-1:0]      index;
  logic [fsda_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/fsda_front.sv
// Front end: sync hunt, payload position and line tracking per byte.
module fsda_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [7:0]     in_byte,
  input  logic           q_full,
  output logic           in_ready,
  output logic           push,
  output fsda_pkg::item_t push_item
);

  logic                          in_payload, in_payload_next;
  logic [fsda_pkg::PROG_W-1:0]   prog, prog_next;
  logic [fsda_pkg::POS_W-1:0]    pos, pos_next;
  logic [fsda_pkg::LINE_W-1:0]   line, line_next;
  logic                          accept;
  logic                          match;
  logic [fsda_pkg::PROG_W-1:0]   hunt_prog;
  logic                          at_end;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept;

  assign match = (prog < fsda_pkg::PROG_W'(fsda_pkg::SYNC_LEN))
              && (in_byte == fsda_pkg::SYNC_WORD[prog]);
  assign hunt_prog = match ? prog + 1'b1
                   : ((in_byte == fsda_pkg::SYNC_A) ? 3'd1 : 3'd0);
  assign at_end = (pos == fsda_pkg::POS_W'(fsda_pkg::PAYLOAD_LEN - 1));

  always_comb begin
    in_payload_next = in_payload;
    prog_next       = prog;
    pos_next        = pos;
    line_next       = line;
    push_item.is_sample  = in_payload;
    push_item.line       = in_payload ? line : '0;
    push_item.value      = in_payload ? in_byte : 8'd0;
    push_item.sync_found = 1'b0;
    push_item.last       = 1'b0;
    if (in_payload) begin
      push_item.last = at_end;
      if (at_end) begin
        in_payload_next = 1'b0;
        pos_next        = '0;
        line_next       = '0;
        prog_next       = '0;
      end else begin
        pos_next  = pos + 1'b1;
        line_next = (line == fsda_pkg::LINE_W'(fsda_pkg::LINES - 1)) ? '0 : line + 1'b1;
      end
    end else begin
      if (hunt_prog == fsda_pkg::PROG_W'(fsda_pkg::SYNC_LEN)) begin
        push_item.sync_found = 1'b1;
        in_payload_next      = 1'b1;
        pos_next             = '0;
        line_next            = '0;
        prog_next            = '0;
      end else begin
        prog_next = hunt_prog;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload <= 1'b0;
      prog       <= '0;
      pos        <= '0;
      line       <= '0;
    end else if (accept) begin
      in_payload <= in_payload_next;
      prog       <= prog_next;
      pos        <= pos_next;
      line       <= line_next;
    end
  end

endmodule

// File: rtl/core/fsda_fifo.sv
// Short item queue between front and back end.
module fsda_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fsda_pkg::item_t push_item,
  input  logic            pop,
  output fsda_pkg::item_t pop_item,
  output logic            full,
  output logic            empty
);

  fsda_pkg::item_t                 mem [fsda_pkg::FIFO_DEPTH];
  logic [fsda_pkg::FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [fsda_pkg::FIFO_CNT_W-1:0] count;

  function automatic logic [fsda_pkg::FIFO_CNT_W-1:0] FIFO_CNT_W_ONE(input logic b);
    FIFO_CNT_W_ONE = {{(fsda_pkg::FIFO_CNT_W-1){1'b0}}, b};
  endfunction

  assign full     = (count == fsda_pkg::FIFO_CNT_W'(fsda_pkg::FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CNT_W_ONE(push) - FIFO_CNT_W_ONE(pop);
    end
  end

endmodule

// File: rtl/core/fsda_back.sv
// Back end: per-line activity counters and the result register.
`include "assert_macros.svh"

module fsda_back (
  input  logic                 clk,
  input  logic                 rst,
  input  fsda_pkg::cfg_t       cfg,
  input  logic                 q_empty,
  input  fsda_pkg::item_t      q_item,
  output logic                 pop,
  fsda_result_if.source        results
);

  logic [fsda_pkg::CNT_W-1:0]  cnt [fsda_pkg::LINES];
  logic [fsda_pkg::CNT_W-1:0]  cnt_cur, cnt_next;
  logic                        loud;
  logic                        out_valid;
  logic                        out_sample, out_active, out_sync, out_last;
  logic [fsda_pkg::LINE_W-1:0] out_line;
  logic [7:0]                  out_value;

  assign pop     = !q_empty && (!out_valid || results.ready);
  assign cnt_cur = cnt[q_item.line];
  assign loud    = $signed(q_item.value) > cfg.threshold;

  always_comb begin
    if (loud) begin
      cnt_next = cfg.hold;
    end else if (cnt_cur != '0) begin
      cnt_next = cnt_cur - 1'b1;
    end else begin
      cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fsda_pkg::LINES; i++) begin
        cnt[i] <= '0;
      end
    end else if (pop && q_item.is_sample) begin
      cnt[q_item.line] <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_sample <= q_item.is_sample;
      out_line   <= q_item.line;
      out_value  <= q_item.value;
      out_active <= q_item.is_sample && (cnt_next != '0);
      out_sync   <= q_item.sync_found;
      out_last   <= q_item.last;
    end
  end

  assign results.valid        = out_valid;
  assign results.sample_valid = out_sample;
  assign results.line_index   = 3'(out_line);
  assign results.sample_value = $signed(out_value);
  assign results.line_active  = out_active;
  assign results.sync_found   = out_sync;
  assign results.frame_last   = out_last;

  `ASSERT_NEXT(a_pop_fills, pop, out_valid)
  `ASSERT_NEXT(a_loud_loads, pop && q_item.is_sample && loud, cnt[out_line] == $past(cfg.hold))
  `ASSERT_NEXT(a_idle_quiet, pop && !q_item.is_sample, !out_active && !out_last)

endmodule

// File: rtl/core/frame_sync_deinterleave_activity_top.sv
// A transferred byte is written into the queue and then popped into the result register, which drives valid.
// Throughput: one byte per cycle while the queue is not full, set by the back end's counter update on each pop.
// A four-entry queue decouples the sync hunt from the result stall.
// Reset (rst, synchronous): hunting, all line counters zero, threshold 0, hold 8000.
// Configuration writes are always accepted; write only while idle.
// Top level of the sync-word deframer with line deinterleave and activity hold.
module frame_sync_deinterleave_activity_top (
  input  logic           clk,
  input  logic           rst,
  fsda_byte_if.sink      bytes,
  fsda_result_if.source  results,
  fsda_cfg_if.sink       cfg
);

  fsda_pkg::cfg_t  cfg_regs;
  fsda_pkg::item_t push_item, pop_item;
  logic            push, pop, q_full, q_empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.threshold <= fsda_pkg::THRESHOLD_RESET;
      cfg_regs.hold      <= fsda_pkg::HOLD_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        fsda_pkg::CFG_THRESHOLD: cfg_regs.threshold <= $signed(cfg.data[7:0]);
        fsda_pkg::CFG_HOLD:      cfg_regs.hold      <= cfg.data[fsda_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  fsda_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bytes.valid),
    .in_byte   (bytes.data_byte),
    .q_full    (q_full),
    .in_ready  (bytes.ready),
    .push      (push),
    .push_item (push_item)
  );

  fsda_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  fsda_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .q_empty (q_empty),
    .q_item  (pop_item),
    .pop     (pop),
    .results (results)
  );

endmodule
